// ===== src/ice_pkg.sv =====
// Shared types and constants of the integer execute unit.
// Depends on nothing; every other file in src imports it.
package ice_pkg;

   localparam int REG_COUNT_DEF  = 32;
   localparam int DATA_WORDS_DEF = 32'h80000;

   localparam logic [4:0] LINK_REG = 5'd31;
   localparam int         LUI_SHIFT = 16;

   // operation codes
   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADDI = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_AND  = 5'd3;
   localparam logic [4:0] OP_ANDI = 5'd4;
   localparam logic [4:0] OP_OR   = 5'd5;
   localparam logic [4:0] OP_ORI  = 5'd6;
   localparam logic [4:0] OP_NOR  = 5'd7;
   localparam logic [4:0] OP_SLL  = 5'd8;
   localparam logic [4:0] OP_SRL  = 5'd9;
   localparam logic [4:0] OP_SLT  = 5'd10;
   localparam logic [4:0] OP_SLTI = 5'd11;
   localparam logic [4:0] OP_BEQ  = 5'd12;
   localparam logic [4:0] OP_BNE  = 5'd13;
   localparam logic [4:0] OP_J    = 5'd14;
   localparam logic [4:0] OP_JAL  = 5'd15;
   localparam logic [4:0] OP_JR   = 5'd16;
   localparam logic [4:0] OP_JALR = 5'd17;
   localparam logic [4:0] OP_LW   = 5'd18;
   localparam logic [4:0] OP_LUI  = 5'd19;
   localparam logic [4:0] OP_SW   = 5'd20;
   localparam logic [4:0] OP_IN   = 5'd21;
   localparam logic [4:0] OP_OUT  = 5'd22;
   localparam logic [4:0] OP_END  = 5'd23;

   // result status codes
   localparam logic [1:0] ST_CONT  = 2'd0;
   localparam logic [1:0] ST_FAULT = 2'd1;
   localparam logic [1:0] ST_END   = 2'd2;

   typedef struct packed {
      logic [4:0]         operation;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg;
      logic [4:0]         second_reg;
      logic signed [31:0] imm;
      logic               in_present;
      logic [7:0]         in_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_pc;
      logic        out_valid;
      logic [7:0]  out_byte;
   } rsp_type;

   // what the execute logic asks of the stores and the result register
   typedef struct packed {
      logic        wr_en;
      logic [4:0]  wr_addr;
      logic [31:0] wr_data;
      logic        mem_rd;
      logic        mem_wr;
      logic [31:0] mem_addr;
      logic [31:0] next_pc;
      logic [1:0]  status;
      logic        out_valid;
      logic [7:0]  out_byte;
   } exec_type;

endpackage

// ===== src/ice_regfile.sv =====
// Register file: synchronous RAM with two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset. Depends on ice_pkg.
module ice_regfile #(
   parameter int REG_COUNT = ice_pkg::REG_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
   input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
   output logic [31:0]                  rd_data_a,
   output logic [31:0]                  rd_data_b,
   input  logic                         wr_en,
   input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
   input  logic [31:0]                  wr_data
);
   import ice_pkg::*;

   logic [31:0]          mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic [31:0]          data_a_ff;
   logic [31:0]          data_b_ff;
   logic                 ok_a_ff;
   logic                 ok_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
         ok_a_ff   <= valid_ff[rd_addr_a];
         ok_b_ff   <= valid_ff[rd_addr_b];
      end
   end

   // never-written registers read as zero
   assign rd_data_a = ok_a_ff ? data_a_ff : '0;
   assign rd_data_b = ok_b_ff ? data_b_ff : '0;

endmodule

// ===== src/ice_dmem.sv =====
// Word-addressed data memory, single port, registered read data.
// Contents are undefined until written. Depends on ice_pkg.
module ice_dmem #(
   parameter int DATA_WORDS = ice_pkg::DATA_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic                          wr_en,
   input  logic [$clog2(DATA_WORDS)-1:0] addr,
   input  logic [31:0]                   wr_data,
   output logic [31:0]                   rd_data
);
   import ice_pkg::*;

   logic [31:0] mem [DATA_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ice_alu.sv =====
// Execute logic: decodes one request against its operands and the counter,
// and says what to write and what to report. Depends on ice_pkg.
module ice_alu #(
   parameter int DATA_WORDS = ice_pkg::DATA_WORDS_DEF
) (
   input  ice_pkg::req_type  req,
   input  logic [31:0]       opnd_a,
   input  logic [31:0]       opnd_b,
   input  logic [31:0]       pc,
   output ice_pkg::exec_type exec
);
   import ice_pkg::*;

   logic [31:0] imm_u;
   logic [31:0] pc_inc;
   logic [31:0] sum;
   logic        addr_ok;
   logic [4:0]  shamt;

   always_comb begin
      imm_u   = req.imm;
      pc_inc  = pc + 32'd1;
      sum     = opnd_a + imm_u;
      addr_ok = sum < 32'(DATA_WORDS);
      shamt   = imm_u[4:0];

      exec           = '0;
      exec.next_pc   = pc_inc;
      exec.mem_addr  = sum;
      exec.status    = ST_CONT;
      exec.wr_addr   = req.dest_reg;

      case (req.operation)
         OP_ADD: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_a + opnd_b;
         end
         OP_ADDI: begin
            exec.wr_en = 1'b1; exec.wr_addr = req.second_reg; exec.wr_data = sum;
         end
         OP_SUB: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_a - opnd_b;
         end
         OP_AND: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_a & opnd_b;
         end
         OP_ANDI: begin
            exec.wr_en = 1'b1; exec.wr_addr = req.second_reg; exec.wr_data = opnd_a & imm_u;
         end
         OP_OR: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_a | opnd_b;
         end
         OP_ORI: begin
            exec.wr_en = 1'b1; exec.wr_addr = req.second_reg; exec.wr_data = opnd_a | imm_u;
         end
         OP_NOR: begin
            exec.wr_en = 1'b1; exec.wr_data = ~(opnd_a | opnd_b);
         end
         OP_SLL: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_b << shamt;
         end
         OP_SRL: begin
            exec.wr_en = 1'b1; exec.wr_data = opnd_b >> shamt;
         end
         OP_SLT: begin
            // set on less than or equal
            exec.wr_en   = 1'b1;
            exec.wr_data = {31'd0, $signed(opnd_a) <= $signed(opnd_b)};
         end
         OP_SLTI: begin
            exec.wr_en   = 1'b1;
            exec.wr_addr = req.second_reg;
            exec.wr_data = {31'd0, $signed(opnd_a) <= req.imm};
         end
         OP_BEQ: begin
            // incremented counter plus imm-1 is the old counter plus imm
            if (opnd_a == opnd_b) begin
               exec.next_pc = pc + imm_u;
            end
         end
         OP_BNE: begin
            if (opnd_a != opnd_b) begin
               exec.next_pc = pc + imm_u;
            end
         end
         OP_J: begin
            exec.next_pc = imm_u;
         end
         OP_JAL: begin
            exec.wr_en = 1'b1; exec.wr_addr = LINK_REG; exec.wr_data = pc_inc;
            exec.next_pc = imm_u;
         end
         OP_JR: begin
            exec.next_pc = opnd_a;
         end
         OP_JALR: begin
            exec.wr_en = 1'b1; exec.wr_addr = LINK_REG; exec.wr_data = pc_inc;
            exec.next_pc = opnd_a;
         end
         OP_LW: begin
            if (addr_ok) begin
               exec.mem_rd = 1'b1;
            end else begin
               exec.status = ST_FAULT;
            end
         end
         OP_LUI: begin
            exec.wr_en   = 1'b1;
            exec.wr_addr = req.second_reg;
            exec.wr_data = imm_u << LUI_SHIFT;
         end
         OP_SW: begin
            if (addr_ok) begin
               exec.mem_wr = 1'b1;
            end else begin
               exec.status = ST_FAULT;
            end
         end
         OP_IN: begin
            if (req.in_present) begin
               exec.wr_en   = 1'b1;
               exec.wr_addr = req.second_reg;
               exec.wr_data = {opnd_b[31:8], req.in_byte};
            end else begin
               exec.status = ST_FAULT;
            end
         end
         OP_OUT: begin
            exec.out_valid = 1'b1;
            exec.out_byte  = opnd_b[7:0];
         end
         OP_END: begin
            exec.status = ST_END;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/integer_core_execute_unit.sv =====
// Top level of the integer execute unit: register-file read, execute, load
// stage and result register. Depends on ice_pkg, ice_regfile, ice_dmem, ice_alu.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    ice_pkg::req_type
//   rsp      out        rsp_valid/stall    ice_pkg::rsp_type
//
// Accepting a request issues the register-file reads; the next cycle executes
// it and loads the result register, so non-load requests go one per cycle
// while the result is not stalled. A load moves on to the load stage for the
// data-memory read and holds off the next request until it writes back.
// Reset clears the register-file valid bits, the counter and the stage flags.
// A stalled result holds the execute stage, which then stalls req.
module integer_core_execute_unit #(
   parameter int REG_COUNT  = ice_pkg::REG_COUNT_DEF,
   parameter int DATA_WORDS = ice_pkg::DATA_WORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ice_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ice_pkg::rsp_type rsp_data
);
   import ice_pkg::*;

   localparam int RW = $clog2(REG_COUNT);
   localparam int AW = $clog2(DATA_WORDS);

   logic        accept;
   logic        rsp_free;
   logic        b_done;
   logic        b_move;
   logic        c_done;

   logic        b_valid_ff, b_valid_in;
   req_type     b_req_ff;
   logic        c_valid_ff, c_valid_in;
   logic [4:0]  c_rt_ff;
   logic [31:0] pc_ff, pc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // write that lands on the edge the reads are issued
   logic          fwd_en_ff;
   logic [RW-1:0] fwd_addr_ff;
   logic [31:0]   fwd_data_ff;

   logic          rf_wr_en;
   logic [RW-1:0] rf_wr_addr;
   logic [31:0]   rf_wr_data;
   logic [31:0]   rf_a;
   logic [31:0]   rf_b;
   logic [31:0]   opnd_a;
   logic [31:0]   opnd_b;
   logic [31:0]   dmem_rd_data;
   exec_type      exec;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign b_move   = b_valid_ff && exec.mem_rd && !c_valid_ff;
   assign b_done   = b_valid_ff && !exec.mem_rd && !c_valid_ff && rsp_free;
   assign c_done   = c_valid_ff && rsp_free;

   // take a request when both stages are empty on the next edge
   assign req_stall = !((!b_valid_ff || b_done) && (!c_valid_ff || c_done));
   assign accept    = req_valid && !req_stall;

   assign opnd_a = (fwd_en_ff && fwd_addr_ff == b_req_ff.src_reg[RW-1:0]) ? fwd_data_ff : rf_a;
   assign opnd_b = (fwd_en_ff && fwd_addr_ff == b_req_ff.second_reg[RW-1:0])
                   ? fwd_data_ff : rf_b;

   ice_alu #(
      .DATA_WORDS(DATA_WORDS)
   ) u_alu (
      .req    (b_req_ff),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .pc     (pc_ff),
      .exec   (exec)
   );

   always_comb begin
      rf_wr_en   = 1'b0;
      rf_wr_addr = exec.wr_addr[RW-1:0];
      rf_wr_data = exec.wr_data;
      if (c_done) begin
         rf_wr_en   = 1'b1;
         rf_wr_addr = c_rt_ff[RW-1:0];
         rf_wr_data = dmem_rd_data;
      end else if (b_done && exec.wr_en) begin
         rf_wr_en = 1'b1;
      end
   end

   ice_regfile #(
      .REG_COUNT(REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_data.src_reg[RW-1:0]),
      .rd_addr_b (req_data.second_reg[RW-1:0]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr_en     (rf_wr_en),
      .wr_addr   (rf_wr_addr),
      .wr_data   (rf_wr_data)
   );

   ice_dmem #(
      .DATA_WORDS(DATA_WORDS)
   ) u_dmem (
      .clock   (clock),
      .rd_en   (b_move),
      .wr_en   (b_done && exec.mem_wr),
      .addr    (exec.mem_addr[AW-1:0]),
      .wr_data (opnd_b),
      .rd_data (dmem_rd_data)
   );

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_done || b_move) begin
         b_valid_in = 1'b0;
      end

      c_valid_in = b_move ? 1'b1 : (c_done ? 1'b0 : c_valid_ff);
      pc_in      = (b_done || b_move) ? exec.next_pc : pc_ff;

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (c_done) begin
         // load retires: counter already advanced when it left execute
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = ST_CONT;
         rsp_data_in.next_pc   = pc_ff;
         rsp_data_in.out_valid = 1'b0;
         rsp_data_in.out_byte  = '0;
      end else if (b_done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = exec.status;
         rsp_data_in.next_pc   = exec.next_pc;
         rsp_data_in.out_valid = exec.out_valid;
         rsp_data_in.out_byte  = exec.out_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_en_ff    <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_en_ff <= rf_wr_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         b_req_ff    <= req_data;
         fwd_addr_ff <= rf_wr_addr;
         fwd_data_ff <= rf_wr_data;
      end
      if (b_move) begin
         c_rt_ff <= b_req_ff.second_reg;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stages_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(b_valid_ff && c_valid_ff))
      else $error("execute and load stages both occupied");

   a_accept_fills_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted request did not reach execute");

   a_load_holds_req: assert property (@(posedge clock) disable iff (reset)
      b_move |-> req_stall)
      else $error("request taken while a load leaves execute");

   a_load_retires: assert property (@(posedge clock) disable iff (reset)
      c_done |=> rsp_valid_ff && !c_valid_ff)
      else $error("load did not retire into the result register");

endmodule

// ===== test/ice_exec_checker.sv =====
// Checker for the integer execute unit: watches both channels, predicts each result.
// Depends on ice_pkg for the request and result types and the operation codes.
`timescale 1ns / 100ps
module ice_exec_checker #(
   parameter int DATA_WORDS = ice_pkg::DATA_WORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ice_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ice_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               fail_count
);
   import ice_pkg::*;

   logic [31:0] gpr [32];
   logic [31:0] model_pc;
   logic [31:0] mem_words [logic [31:0]];
   rsp_type     results_due [$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Execute one instruction on the shadow state and return its result.
   function automatic rsp_type retire_instruction(input req_type r);
      rsp_type     res;
      logic [31:0] a, b, k, pc_inc, addr;
      a      = gpr[r.src_reg];
      b      = gpr[r.second_reg];
      k      = r.imm;
      pc_inc = model_pc + 32'd1;
      addr   = a + k;
      res    = '0;
      res.status = ST_CONT;
      case (r.operation)
         OP_ADD:  gpr[r.dest_reg] = a + b;
         OP_ADDI: gpr[r.second_reg] = a + k;
         OP_SUB:  gpr[r.dest_reg] = a - b;
         OP_AND:  gpr[r.dest_reg] = a & b;
         OP_ANDI: gpr[r.second_reg] = a & k;
         OP_OR:   gpr[r.dest_reg] = a | b;
         OP_ORI:  gpr[r.second_reg] = a | k;
         OP_NOR:  gpr[r.dest_reg] = ~(a | b);
         OP_SLL:  gpr[r.dest_reg] = b << k[4:0];
         OP_SRL:  gpr[r.dest_reg] = b >> k[4:0];
         // less-or-equal, not strictly less
         OP_SLT:  gpr[r.dest_reg] = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
         OP_SLTI: gpr[r.second_reg] = ($signed(a) <= $signed(k)) ? 32'd1 : 32'd0;
         OP_BEQ:  if (a == b) pc_inc = pc_inc + k - 32'd1;
         OP_BNE:  if (a != b) pc_inc = pc_inc + k - 32'd1;
         OP_J:    pc_inc = k;
         OP_JAL: begin
            gpr[LINK_REG] = pc_inc;
            pc_inc = k;
         end
         OP_JR:   pc_inc = a;
         OP_JALR: begin
            gpr[LINK_REG] = pc_inc;
            pc_inc = a;
         end
         OP_LW: begin
            if (addr < 32'(DATA_WORDS)) gpr[r.second_reg] = mem_words[addr];
            else res.status = ST_FAULT;
         end
         OP_LUI:  gpr[r.second_reg] = k << LUI_SHIFT;
         OP_SW: begin
            if (addr < 32'(DATA_WORDS)) mem_words[addr] = b;
            else res.status = ST_FAULT;
         end
         OP_IN: begin
            if (r.in_present) gpr[r.second_reg] = {b[31:8], r.in_byte};
            else res.status = ST_FAULT;
         end
         OP_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = b[7:0];
         end
         OP_END:  res.status = ST_END;
         default: ;
      endcase
      model_pc    = pc_inc;
      res.next_pc = pc_inc;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         model_pc = '0;
         mem_words.delete();
         results_due.delete();
      end else begin
         if ((req_valid & ~req_stall) === 1'b1)
            results_due.push_back(retire_instruction(req_data));
         if ((rsp_valid & ~rsp_stall) === 1'b1) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with no request waiting");
            end else begin
               want = results_due.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("next_pc", rsp_data.next_pc, want.next_pc);
               check_field("out_valid", 32'(rsp_data.out_valid), 32'(want.out_valid));
               check_field("out_byte", 32'(rsp_data.out_byte), 32'(want.out_byte));
            end
         end
      end
      outstanding <= results_due.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Top of the execute unit testbench: clock, reset, request and result drivers, verdict.
// Depends on ice_pkg, integer_core_execute_unit and ice_exec_checker.
`timescale 1ns / 100ps
module tb_top;
   import ice_pkg::*;

   localparam int DATA_WORDS  = DATA_WORDS_DEF;
   localparam int ITEM_TARGET = 850;
   localparam int IDLE_LIMIT  = 3000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      outstanding;
   int      fail_count;

   bit          calm = 1'b0;
   int          idle_cycles = 0;
   int          issued = 0;
   bit          stored_words [logic [31:0]];
   logic [31:0] stored_list [$];

   integer_core_execute_unit #(.DATA_WORDS(DATA_WORDS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   ice_exec_checker #(.DATA_WORDS(DATA_WORDS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .outstanding(outstanding), .fail_count(fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      if (calm) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic req_type encode(input logic [4:0] op, input logic [4:0] rd,
                                      input logic [4:0] rs, input logic [4:0] rt,
                                      input logic [31:0] k, input logic have = 1'b0,
                                      input logic [7:0] in_b = 8'h00);
      req_type r;
      r.operation  = op;
      r.dest_reg   = rd;
      r.src_reg    = rs;
      r.second_reg = rt;
      r.imm        = k;
      r.in_present = have;
      r.in_byte    = in_b;
      return r;
   endfunction

   function automatic logic [31:0] pick_imm();
      case ($urandom_range(0, 4))
         0: return 32'($urandom_range(0, 16)) - 32'd8;
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFF;
               3: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 63);
         6, 7: return 32'(DATA_WORDS - 1) - $urandom_range(0, 15);
         default: return $urandom_range(0, DATA_WORDS - 1);
      endcase
   endfunction

   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while ((req_valid & ~req_stall) !== 1'b1);
      issued++;
   endtask

   // Hold requests until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic note_store(input logic [31:0] addr);
      if (!stored_words.exists(addr)) begin
         stored_words[addr] = 1'b1;
         stored_list.push_back(addr);
      end
   endtask

   // Load a known base value, then store, load a written word, or access out of range.
   task automatic memory_sequence();
      logic [4:0]  base_reg, data_reg;
      logic [31:0] base_val, addr;
      int unsigned kind;
      base_reg = 5'($urandom);
      data_reg = 5'($urandom);
      base_val = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4096);
      kind     = $urandom_range(0, 9);
      send_request(encode(OP_ANDI, 5'($urandom), base_reg, base_reg, 32'd0));
      send_request(encode(OP_ORI, 5'($urandom), base_reg, base_reg, base_val));
      if (kind < 4 || stored_list.size() == 0) begin
         addr = pick_address();
         send_request(encode(OP_SW, 5'($urandom), base_reg, data_reg, addr - base_val));
         note_store(addr);
      end else if (kind < 8) begin
         addr = stored_list[$urandom_range(0, stored_list.size() - 1)];
         send_request(encode(OP_LW, 5'($urandom), base_reg, data_reg, addr - base_val));
      end else begin
         case ($urandom_range(0, 2))
            0: addr = 32'(DATA_WORDS) + $urandom_range(0, 1000);
            1: addr = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: addr = $urandom | 32'h8000_0000;
         endcase
         send_request(encode(($urandom_range(0, 1) == 0) ? OP_LW : OP_SW, 5'($urandom),
                             base_reg, data_reg, addr - base_val));
      end
   endtask

   task automatic random_instruction();
      logic [4:0] op;
      op = 5'($urandom);
      // random instructions issue no loads; memory_sequence loads words known to be written
      if (op == OP_LW) op = OP_SW;
      send_request(encode(op, 5'($urandom), 5'($urandom), 5'($urandom), pick_imm(),
                          1'($urandom), 8'($urandom)));
   endtask

   task automatic directed_requests();
      send_request(encode(OP_ORI, 5'd0, 5'd0, 5'd1, 32'hFFFF_FFFF));
      send_request(encode(OP_LUI, 5'd0, 5'd0, 5'd2, 32'h0000_7FFF));
      send_request(encode(OP_ADD, 5'd3, 5'd1, 5'd2, 32'd0));
      send_request(encode(OP_SUB, 5'd4, 5'd0, 5'd1, 32'd0));
      send_request(encode(OP_SLT, 5'd5, 5'd1, 5'd1, 32'd0));
      send_request(encode(OP_SLTI, 5'd0, 5'd2, 5'd6, 32'h8000_0000));
      send_request(encode(OP_NOR, 5'd7, 5'd1, 5'd0, 32'd0));
      send_request(encode(OP_SLL, 5'd8, 5'd0, 5'd1, 32'hFFFF_FFFF));
      send_request(encode(OP_SRL, 5'd9, 5'd0, 5'd1, 32'd33));
      send_request(encode(OP_AND, 5'd10, 5'd3, 5'd2, 32'd0));
      send_request(encode(OP_ANDI, 5'd0, 5'd1, 5'd11, 32'h8000_0000));
      send_request(encode(OP_OR, 5'd12, 5'd4, 5'd2, 32'd0));
      send_request(encode(OP_ADDI, 5'd0, 5'd2, 5'd13, 32'h7FFF_FFFF));
      // both ends of the data memory, then read back the top word
      send_request(encode(OP_SW, 5'd0, 5'd0, 5'd1, 32'(DATA_WORDS - 1)));
      note_store(32'(DATA_WORDS - 1));
      send_request(encode(OP_SW, 5'd0, 5'd0, 5'd3, 32'd0));
      note_store(32'd0);
      send_request(encode(OP_LW, 5'd0, 5'd0, 5'd14, 32'(DATA_WORDS - 1)));
      send_request(encode(OP_SW, 5'd0, 5'd0, 5'd1, 32'(DATA_WORDS)));
      send_request(encode(OP_LW, 5'd0, 5'd0, 5'd14, 32'hFFFF_FFFF));
      send_request(encode(OP_IN, 5'd0, 5'd0, 5'd15, 32'd0, 1'b0, 8'h5A));
      send_request(encode(OP_IN, 5'd0, 5'd0, 5'd1, 32'd0, 1'b1, 8'hA5));
      send_request(encode(OP_OUT, 5'd0, 5'd0, 5'd3, 32'd0));
      send_request(encode(OP_BEQ, 5'd0, 5'd0, 5'd0, 32'h8000_0000));
      send_request(encode(OP_BNE, 5'd0, 5'd0, 5'd1, 32'd0));
      send_request(encode(OP_J, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF));
      send_request(encode(OP_JAL, 5'd0, 5'd0, 5'd0, 32'd5));
      // jump register reads the link register before overwriting it
      send_request(encode(OP_JALR, 5'd0, 5'd31, 5'd0, 32'd0));
      send_request(encode(OP_JR, 5'd0, 5'd4, 5'd0, 32'd0));
      send_request(encode(OP_END, 5'd0, 5'd0, 5'd0, 32'd0));
      send_request(encode(5'($urandom_range(24, 31)), 5'd1, 5'd2, 5'd3, 32'hFFFF_FFFF));
      send_request(encode(OP_ADDI, 5'd0, 5'd0, 5'd0, 32'd3));
   endtask

   // Receiver: after each result, stall for a drawn number of cycles.
   initial begin
      int unsigned hold;
      @(negedge reset);
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while ((rsp_valid & ~rsp_stall) !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if ((req_valid & ~req_stall) === 1'b1 || (rsp_valid & ~rsp_stall) === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_requests();
      drain();
      while (issued < ITEM_TARGET) begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         if (!paused && issued >= ITEM_TARGET / 2) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 4) memory_sequence();
         else random_instruction();
      end
      drain();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
